FILE: rtl/core/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
// Used by the level rows, the top level and both checkers; depends on nothing.
package mlfq_pkg;

    localparam int NUM_TASKS_DEF  = 64;
    localparam int NUM_LEVELS_DEF = 5;
    localparam logic [15:0] AGE_LIMIT_RST = 16'd30;

    // Widest task id that any legal NUM_TASKS (up to 256) needs.
    localparam int ID_MAX_W = 8;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MD_ADMIT   = 2'd0,
        MD_REQUEUE = 2'd1,
        MD_REMOVE  = 2'd2,
        MD_SCHED   = 2'd3
    } t_mode;

    // Per-cycle operation on one level row.
    typedef enum logic [1:0] {
        LOP_NONE   = 2'd0,
        LOP_KEEP   = 2'd1,
        LOP_DROP   = 2'd2,
        LOP_APPEND = 2'd3
    } t_lvl_op;

    typedef struct packed {
        t_lvl_op             op;
        logic [ID_MAX_W-1:0] id;
    } t_lvl_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TLRD,
        S_TL,
        S_DUP,
        S_REM,
        S_SCAN_RD,
        S_SCAN_AGE,
        S_POP,
        S_OUT
    } t_state;

endpackage

FILE: rtl/core/mlfq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mlfq_cell.sv
// One FIFO slot of a level row: holds a task id, takes its neighbor's id on a
// shift, or a new id on a load. No package needed.
module mlfq_cell #(
    parameter int IDW = 6
) (
    input  logic           i_clk,
    input  logic           i_shift,
    input  logic           i_load,
    input  logic [IDW-1:0] i_load_id,
    input  logic [IDW-1:0] i_next_id,
    output logic [IDW-1:0] o_id
);

    logic [IDW-1:0] r_id;
    logic [IDW-1:0] n_id;

    always_comb begin
        n_id = r_id;
        if (i_load) begin
            n_id = i_load_id;
        end else if (i_shift) begin
            n_id = i_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_id = r_id;

endmodule

FILE: rtl/core/mlfq_level.sv
// One priority level: a row of mlfq_cell slots forming a FIFO with a count.
// Depends on mlfq_pkg (command struct) and mlfq_cell.
module mlfq_level #(
    parameter int NUM_TASKS = mlfq_pkg::NUM_TASKS_DEF,
    parameter int IDW       = $clog2(NUM_TASKS),
    parameter int CNTW      = $clog2(NUM_TASKS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlfq_pkg::t_lvl_cmd i_cmd,
    output logic [IDW-1:0]    o_head,
    output logic [CNTW-1:0]   o_cnt
);

    logic [IDW-1:0]  ids [NUM_TASKS];
    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] n_cnt;
    logic [CNTW-1:0] last;
    logic            shift;
    logic [IDW-1:0]  load_id;

    // Keep rotates the head to the tail, drop pops it, append adds at the tail.
    assign shift   = (i_cmd.op == mlfq_pkg::LOP_KEEP) || (i_cmd.op == mlfq_pkg::LOP_DROP);
    assign last    = r_cnt - CNTW'(1);
    assign load_id = (i_cmd.op == mlfq_pkg::LOP_KEEP) ? ids[0] : IDW'(i_cmd.id);

    for (genvar k = 0; k < NUM_TASKS; k++) begin : g_cell
        logic ld;
        assign ld = ((i_cmd.op == mlfq_pkg::LOP_KEEP) && (last == CNTW'(k))) ||
                    ((i_cmd.op == mlfq_pkg::LOP_APPEND) && (r_cnt == CNTW'(k)));
        mlfq_cell #(.IDW(IDW)) u_cell (
            .i_clk     (i_clk),
            .i_shift   (shift),
            .i_load    (ld),
            .i_load_id (load_id),
            .i_next_id ((k == NUM_TASKS - 1) ? ids[k] : ids[(k + 1) % NUM_TASKS]),
            .o_id      (ids[k])
        );
    end

    always_comb begin
        n_cnt = r_cnt;
        case (i_cmd.op)
            mlfq_pkg::LOP_DROP:   n_cnt = r_cnt - CNTW'(1);
            mlfq_pkg::LOP_APPEND: n_cnt = r_cnt + CNTW'(1);
            default:              n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_head = ids[0];
    assign o_cnt  = r_cnt;

endmodule

FILE: rtl/core/multilevel_feedback_queue_scheduler.sv
// Top level of the multilevel feedback queue scheduler with aging.
// Depends on mlfq_pkg, mlfq_level (with mlfq_cell) and mlfq_ram.
//
// The block keeps NUM_LEVELS FIFOs of task ids, level 0 first, each a row of
// NUM_TASKS cells that rotates one place per cycle in a search or deletion.
// Every search or deletion rotates a level once around its occupied cells.
// Admit searches level 0 for a duplicate, then appends; requeue and remove
// read the task's level, then search and append or delete. Schedule reads
// and ages each entry on levels 1 and below, gives each entry over the age
// limit a duplicate search of the next higher level, then pops the highest
// non-empty level. A result sits in an output register and the next item is
// taken while it waits. Entry ticks live in a RAM of NUM_TASKS words; the
// per-task level lives in a RAM whose entries read as zero until first
// written. age_limit is written through i_cfg_we and i_cfg_data; the user
// must write it only while the block is idle; the block does not enforce it.
module multilevel_feedback_queue_scheduler #(
    parameter int NUM_TASKS  = mlfq_pkg::NUM_TASKS_DEF,
    parameter int NUM_LEVELS = mlfq_pkg::NUM_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_task_id,
    input  logic        i_demote,
    input  logic [31:0] i_now_tick,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_chosen_id,
    output logic [2:0]  o_chosen_level,
    output logic [6:0]  o_promoted_count
);

    localparam int IDW  = $clog2(NUM_TASKS);
    localparam int CNTW = $clog2(NUM_TASKS + 1);
    localparam int LVW  = $clog2(NUM_LEVELS);
    localparam logic [LVW-1:0] LAST_LVL = LVW'(NUM_LEVELS - 1);

    mlfq_pkg::t_state  r_state, n_state;
    mlfq_pkg::t_mode   r_mode;
    mlfq_pkg::t_status r_status, n_status;
    logic [15:0]       r_age_limit;
    logic [IDW-1:0]    r_id;
    logic              r_demote;
    logic [31:0]       r_now;
    logic [IDW-1:0]    r_key, n_key;
    logic [LVW-1:0]    r_lvl, n_lvl;
    logic [LVW-1:0]    r_tgt, n_tgt;
    logic [CNTW-1:0]   r_rem, n_rem;
    logic [CNTW-1:0]   r_rem_scan, n_rem_scan;
    logic              r_flag, n_flag;
    logic              r_aging, n_aging;
    logic [5:0]        r_cid, n_cid;
    logic [2:0]        r_clv, n_clv;
    logic [6:0]        r_prom, n_prom;
    logic [NUM_TASKS-1:0] r_tl_vld;

    logic              r_ovalid;
    logic [2:0]        r_ostatus;
    logic [5:0]        r_ocid;
    logic [2:0]        r_oclv;
    logic [6:0]        r_oprom;

    mlfq_pkg::t_lvl_cmd cmd [NUM_LEVELS];
    logic [IDW-1:0]     head [NUM_LEVELS];
    logic [CNTW-1:0]    cnt [NUM_LEVELS];

    logic              tick_we;
    logic [IDW-1:0]    tick_raddr;
    logic [31:0]       tick_rdata;
    logic              tl_we;
    logic [LVW-1:0]    tl_wdata;
    logic [LVW-1:0]    tl_rdata;
    logic              accept;
    logic              out_load;
    logic [LVW-1:0]    lv;
    logic [31:0]       age;
    logic              pop_found;
    logic [LVW-1:0]    pop_lvl;

    assign o_in_ready = (r_state == mlfq_pkg::S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == mlfq_pkg::S_OUT) && (!r_ovalid || i_out_ready);
    assign age        = r_now - tick_rdata;

    for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_lvl
        mlfq_level #(.NUM_TASKS(NUM_TASKS), .IDW(IDW), .CNTW(CNTW)) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[l]),
            .o_head  (head[l]),
            .o_cnt   (cnt[l])
        );
    end

    mlfq_ram #(.WIDTH(32), .DEPTH(NUM_TASKS)) u_tick_ram (
        .i_clk   (i_clk),
        .i_we    (tick_we),
        .i_waddr (r_key),
        .i_wdata (r_now),
        .i_raddr (tick_raddr),
        .o_rdata (tick_rdata)
    );

    // Task level store; the write address is always r_key.
    mlfq_ram #(.WIDTH(LVW), .DEPTH(NUM_TASKS)) u_tl_ram (
        .i_clk   (i_clk),
        .i_we    (tl_we),
        .i_waddr (r_key),
        .i_wdata (tl_wdata),
        .i_raddr (r_id),
        .o_rdata (tl_rdata)
    );

    // Highest non-empty level for the pop at the end of a schedule.
    always_comb begin
        pop_found = 1'b0;
        pop_lvl   = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (cnt[l] != '0) begin
                pop_found = 1'b1;
                pop_lvl   = LVW'(l);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        n_key      = r_key;
        n_lvl      = r_lvl;
        n_tgt      = r_tgt;
        n_rem      = r_rem;
        n_rem_scan = r_rem_scan;
        n_flag     = r_flag;
        n_aging    = r_aging;
        n_cid      = r_cid;
        n_clv      = r_clv;
        n_prom     = r_prom;
        tick_we    = 1'b0;
        tick_raddr = head[r_lvl];
        tl_we      = 1'b0;
        tl_wdata   = r_tgt;
        lv         = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            cmd[l].op = mlfq_pkg::LOP_NONE;
            cmd[l].id = mlfq_pkg::ID_MAX_W'(r_key);
        end

        unique case (r_state)
            mlfq_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = mlfq_pkg::ST_DONE;
                    n_cid    = '0;
                    n_clv    = '0;
                    n_prom   = '0;
                    n_key    = IDW'(i_task_id);
                    n_tgt    = '0;
                    n_rem    = cnt[0];
                    n_flag   = 1'b0;
                    n_aging  = 1'b0;
                    if (i_mode == mlfq_pkg::MD_SCHED) begin
                        n_lvl      = LVW'(1);
                        n_rem_scan = cnt[1];
                        n_state    = mlfq_pkg::S_SCAN_RD;
                    end else if (32'(i_task_id) >= NUM_TASKS) begin
                        n_status = mlfq_pkg::ST_NOTFOUND;
                        n_state  = mlfq_pkg::S_OUT;
                    end else if (i_mode == mlfq_pkg::MD_ADMIT) begin
                        n_state = mlfq_pkg::S_DUP;
                    end else begin
                        n_state = mlfq_pkg::S_TLRD;
                    end
                end
            end
            mlfq_pkg::S_TLRD: begin
                n_state = mlfq_pkg::S_TL;
            end
            mlfq_pkg::S_TL: begin
                lv = r_tl_vld[r_id] ? tl_rdata : '0;
                if (lv > LAST_LVL) begin
                    lv = LAST_LVL;
                end
                n_flag = 1'b0;
                if (r_mode == mlfq_pkg::MD_REQUEUE) begin
                    if (r_demote && (lv < LAST_LVL)) begin
                        lv = lv + LVW'(1);
                    end
                    // The lowered level is kept even if the append is refused.
                    tl_we    = 1'b1;
                    tl_wdata = lv;
                    n_state  = mlfq_pkg::S_DUP;
                end else begin
                    n_state = mlfq_pkg::S_REM;
                end
                n_tgt = lv;
                n_rem = cnt[lv];
            end
            mlfq_pkg::S_DUP: begin
                if (r_rem != '0) begin
                    cmd[r_tgt].op = mlfq_pkg::LOP_KEEP;
                    if (head[r_tgt] == r_key) begin
                        n_flag = 1'b1;
                    end
                    n_rem = r_rem - CNTW'(1);
                end else if (!r_aging) begin
                    if (r_flag) begin
                        n_status = mlfq_pkg::ST_DUP;
                    end else if (32'(cnt[r_tgt]) >= NUM_TASKS) begin
                        n_status = mlfq_pkg::ST_FULL;
                    end else begin
                        cmd[r_tgt].op = mlfq_pkg::LOP_APPEND;
                        tick_we       = 1'b1;
                        tl_we         = 1'b1;
                    end
                    n_state = mlfq_pkg::S_OUT;
                end else begin
                    // Aged entry: dropped if the upper level holds it, kept
                    // if the upper level is full, otherwise moved up.
                    if (r_flag) begin
                        cmd[r_lvl].op = mlfq_pkg::LOP_DROP;
                    end else if (32'(cnt[r_tgt]) >= NUM_TASKS) begin
                        cmd[r_lvl].op = mlfq_pkg::LOP_KEEP;
                    end else begin
                        cmd[r_lvl].op = mlfq_pkg::LOP_DROP;
                        cmd[r_tgt].op = mlfq_pkg::LOP_APPEND;
                        tick_we       = 1'b1;
                        tl_we         = 1'b1;
                        if (r_prom != 7'd127) begin
                            n_prom = r_prom + 7'd1;
                        end
                    end
                    n_state = mlfq_pkg::S_SCAN_RD;
                end
            end
            mlfq_pkg::S_REM: begin
                if (r_rem != '0) begin
                    if (head[r_tgt] == r_key) begin
                        cmd[r_tgt].op = mlfq_pkg::LOP_DROP;
                        n_flag        = 1'b1;
                    end else begin
                        cmd[r_tgt].op = mlfq_pkg::LOP_KEEP;
                    end
                    n_rem = r_rem - CNTW'(1);
                end else begin
                    n_status = r_flag ? mlfq_pkg::ST_DONE : mlfq_pkg::ST_NOTFOUND;
                    n_state  = mlfq_pkg::S_OUT;
                end
            end
            mlfq_pkg::S_SCAN_RD: begin
                if (r_rem_scan == '0) begin
                    if (r_lvl == LAST_LVL) begin
                        n_state = mlfq_pkg::S_POP;
                    end else begin
                        n_lvl      = r_lvl + LVW'(1);
                        n_rem_scan = cnt[r_lvl + LVW'(1)];
                    end
                end else begin
                    tick_raddr = head[r_lvl];
                    n_state    = mlfq_pkg::S_SCAN_AGE;
                end
            end
            mlfq_pkg::S_SCAN_AGE: begin
                n_rem_scan = r_rem_scan - CNTW'(1);
                if (age > {16'd0, r_age_limit}) begin
                    n_key   = head[r_lvl];
                    n_tgt   = r_lvl - LVW'(1);
                    n_rem   = cnt[r_lvl - LVW'(1)];
                    n_flag  = 1'b0;
                    n_aging = 1'b1;
                    n_state = mlfq_pkg::S_DUP;
                end else begin
                    cmd[r_lvl].op = mlfq_pkg::LOP_KEEP;
                    n_state       = mlfq_pkg::S_SCAN_RD;
                end
            end
            mlfq_pkg::S_POP: begin
                if (pop_found) begin
                    cmd[pop_lvl].op = mlfq_pkg::LOP_DROP;
                    n_cid           = 6'(head[pop_lvl]);
                    n_clv           = 3'(pop_lvl);
                end else begin
                    n_status = mlfq_pkg::ST_EMPTY;
                end
                n_state = mlfq_pkg::S_OUT;
            end
            mlfq_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = mlfq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mlfq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlfq_pkg::S_IDLE;
            r_age_limit <= mlfq_pkg::AGE_LIMIT_RST;
            r_tl_vld    <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_age_limit <= i_cfg_data;
            end
            if (tl_we) begin
                r_tl_vld[r_key] <= 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= mlfq_pkg::t_mode'(i_mode);
            r_id     <= IDW'(i_task_id);
            r_demote <= i_demote;
            r_now    <= i_now_tick;
        end
        r_status   <= n_status;
        r_key      <= n_key;
        r_lvl      <= n_lvl;
        r_tgt      <= n_tgt;
        r_rem      <= n_rem;
        r_rem_scan <= n_rem_scan;
        r_flag     <= n_flag;
        r_aging    <= n_aging;
        r_cid      <= n_cid;
        r_clv      <= n_clv;
        r_prom     <= n_prom;
        if (out_load) begin
            r_ostatus <= r_status;
            r_ocid    <= r_cid;
            r_oclv    <= r_clv;
            r_oprom   <= r_prom;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_chosen_id      = r_ocid;
    assign o_chosen_level   = r_oclv;
    assign o_promoted_count = r_oprom;

endmodule

FILE: rtl/core/mlfq_checker.sv
// Port-level checks of the scheduler's result channel, bound to the top level.
// Depends on mlfq_pkg and multilevel_feedback_queue_scheduler.
module mlfq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_status,
    input logic [5:0] o_chosen_id,
    input logic [2:0] o_chosen_level
);

    // A reset leaves no item pending on the result side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= mlfq_pkg::ST_FULL)
        else $error("status code out of range");

    // Only a successful pop names a task.
    a_chosen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != mlfq_pkg::ST_DONE
            |-> o_chosen_id == 6'd0 && o_chosen_level == 3'd0)
        else $error("chosen task reported without a pop");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_chosen_id    (o_chosen_id),
    .o_chosen_level (o_chosen_level)
);

FILE: test/mlfq_checker.sv
`timescale 1ns / 1ps
// Checker for the multilevel feedback queue scheduler: it predicts each result and compares it.
// Depends on mlfq_pkg. It only watches the block's ports.
module mlfq_tb_checker
    import mlfq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [5:0]  i_task_id,
    input  logic        i_demote,
    input  logic [31:0] i_now_tick,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [5:0]  i_chosen_id,
    input  logic [2:0]  i_chosen_level,
    input  logic [6:0]  i_promoted_count,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NT = NUM_TASKS_DEF;
    localparam int NL = NUM_LEVELS_DEF;

    typedef struct {
        t_status  status;
        bit [5:0] chosen_id;
        bit [2:0] chosen_level;
        bit [6:0] promoted;
    } sched_result_t;

    bit [15:0]     age_limit;
    bit [5:0]      level_fifo [NL][$];
    bit [2:0]      task_lvl [NT];
    bit [31:0]     enter_tick [NT];
    sched_result_t pending_results [$];
    int            fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_results.size();

    // Searches only the given level.
    function automatic int find_task(int lvl, bit [5:0] id);
        for (int k = 0; k < level_fifo[lvl].size(); k++) begin
            if (level_fifo[lvl][k] == id) return k;
        end
        return -1;
    endfunction

    function automatic t_status append_task(int lvl, bit [5:0] id, bit [31:0] now);
        if (find_task(lvl, id) >= 0) return ST_DUP;
        if (level_fifo[lvl].size() >= NT) return ST_FULL;
        level_fifo[lvl].push_back(id);
        enter_tick[id] = now;
        task_lvl[id]   = 3'(lvl);
        return ST_DONE;
    endfunction

    // Works out the one result of an event and updates the queues.
    task automatic schedule_event(input t_mode m, input bit [5:0] id, input bit dem,
                                  input bit [31:0] now);
        sched_result_t r;
        int            j;
        int            lvl;
        int            pos;
        bit [5:0]      t;
        bit [31:0]     age;
        r = '{ST_DONE, 6'd0, 3'd0, 7'd0};
        case (m)
            MD_SCHED: begin
                // Aging walks levels 1 and below, head to tail; a moved entry
                // lands on the level above, where it is not scanned again.
                for (int i = 1; i < NL; i++) begin
                    j = 0;
                    while (j < level_fifo[i].size()) begin
                        t   = level_fifo[i][j];
                        age = now - enter_tick[t];
                        if (age > {16'd0, age_limit}) begin
                            if (find_task(i - 1, t) >= 0) begin
                                level_fifo[i].delete(j);
                            end else if (level_fifo[i - 1].size() >= NT) begin
                                j++;
                            end else begin
                                level_fifo[i].delete(j);
                                void'(append_task(i - 1, t, now));
                                if (r.promoted < 7'd127) r.promoted++;
                            end
                        end else begin
                            j++;
                        end
                    end
                end
                r.status = ST_EMPTY;
                for (int l = 0; l < NL; l++) begin
                    if (level_fifo[l].size() > 0) begin
                        r.chosen_id    = level_fifo[l].pop_front();
                        r.chosen_level = 3'(l);
                        r.status       = ST_DONE;
                        break;
                    end
                end
            end
            MD_ADMIT: r.status = append_task(0, id, now);
            MD_REQUEUE: begin
                lvl = (task_lvl[id] >= NL) ? NL - 1 : task_lvl[id];
                if (dem && lvl < NL - 1) lvl++;
                // The lowered level sticks even when the append is refused.
                task_lvl[id] = 3'(lvl);
                r.status     = append_task(lvl, id, now);
            end
            default: begin
                lvl = (task_lvl[id] >= NL) ? NL - 1 : task_lvl[id];
                pos = find_task(lvl, id);
                if (pos < 0) r.status = ST_NOTFOUND;
                else level_fifo[lvl].delete(pos);
            end
        endcase
        pending_results.push_back(r);
    endtask

    task automatic report(input string what, input sched_result_t e);
        fail_count++;
        if (fail_count <= 10)
            $display({"%0t mismatch %s: expected st=%0d id=%0d lvl=%0d prom=%0d,",
                      " got st=%0d id=%0d lvl=%0d prom=%0d"},
                     $realtime, what, e.status, e.chosen_id, e.chosen_level, e.promoted,
                     i_status, i_chosen_id, i_chosen_level, i_promoted_count);
    endtask

    always @(posedge i_clk) begin
        sched_result_t e;
        if (!i_rst_n) begin
            age_limit = AGE_LIMIT_RST;
            for (int l = 0; l < NL; l++) level_fifo[l].delete();
            foreach (task_lvl[k]) begin
                task_lvl[k]   = '0;
                enter_tick[k] = '0;
            end
            pending_results.delete();
            fail_count = 0;
        end else begin
            if (i_cfg_we) age_limit = i_cfg_data;
            // A result leaving at this edge belongs to an older item.
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    e = '{ST_DONE, 6'd0, 3'd0, 7'd0};
                    report("unexpected result", e);
                end else begin
                    e = pending_results.pop_front();
                    if (i_status !== e.status || i_chosen_id !== e.chosen_id ||
                        i_chosen_level !== e.chosen_level || i_promoted_count !== e.promoted)
                        report("result", e);
                end
            end
            if (i_in_valid && i_in_ready)
                schedule_event(t_mode'(i_mode), i_task_id, i_demote, i_now_tick);
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, stimulus and the verdict.
// Depends on mlfq_pkg, mlfq_tb_checker and the scheduler RTL.
module testbench;
    import mlfq_pkg::*;

    // Cycles without any handshake before the run is declared hung.
    localparam int HANG_LIMIT  = 100000;
    // Settling time after the last result before a register write or the verdict.
    localparam int DRAIN_CYCLES = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = '0;
    logic [5:0]  i_task_id = '0;
    logic        i_demote = 1'b0;
    logic [31:0] i_now_tick = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [5:0]  o_chosen_id;
    logic [2:0]  o_chosen_level;
    logic [6:0]  o_promoted_count;

    int        fail_count;
    int        pending;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles = 0;
    bit [31:0] tick = 32'd100;

    always #6 i_clk = ~i_clk;

    multilevel_feedback_queue_scheduler u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_in_valid, .o_in_ready, .i_mode, .i_task_id, .i_demote, .i_now_tick,
        .o_out_valid, .i_out_ready, .o_status, .o_chosen_id, .o_chosen_level,
        .o_promoted_count
    );

    mlfq_tb_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_mode, .i_task_id, .i_demote,
        .i_now_tick, .i_out_valid(o_out_valid), .i_out_ready,
        .i_status(o_status), .i_chosen_id(o_chosen_id), .i_chosen_level(o_chosen_level),
        .i_promoted_count(o_promoted_count), .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls at random, independently of the sender.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // The watchdog restarts whenever either channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (i_rst_n) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Presents one item and holds it until the block takes it. Valid is only
    // lowered when the sender decides to idle before this item, or by drain.
    task automatic send_event(input t_mode m, input bit [5:0] id, input bit dem,
                              input bit [31:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_task_id  <= id;
        i_demote   <= dem;
        i_now_tick <= now;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Waits until every result is back and the block has settled.
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_age_limit(input bit [15:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random traffic: mostly a small pool of tasks so that levels fill up and
    // duplicates, demotions and aging happen often.
    task automatic random_phase(input int count);
        int       pick;
        t_mode    m;
        bit [5:0] id;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 25) m = MD_ADMIT;
            else if (pick < 55) m = MD_REQUEUE;
            else if (pick < 70) m = MD_REMOVE;
            else m = MD_SCHED;
            id = ($urandom_range(99) < 80) ? 6'($urandom_range(15)) : 6'($urandom);
            if ($urandom_range(99) < 3) tick = $urandom;
            else tick = tick + $urandom_range(20);
            send_event(m, id, 1'($urandom), tick);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, age limit at its reset value.
        send_event(MD_SCHED, 6'd0, 1'b0, 32'd0);          // all levels empty
        send_event(MD_REMOVE, 6'd5, 1'b0, 32'd1);         // remove of an absent task
        send_event(MD_ADMIT, 6'd0, 1'b0, 32'd2);
        send_event(MD_ADMIT, 6'd63, 1'b1, 32'd3);
        send_event(MD_ADMIT, 6'd0, 1'b0, 32'd4);          // duplicate on level 0
        send_event(MD_REQUEUE, 6'd63, 1'b1, 32'd5);       // demoted to level 1
        send_event(MD_REQUEUE, 6'd63, 1'b0, 32'd6);       // already on level 1
        for (int k = 0; k < 4; k++)                       // demoted level by level down to the last level
            send_event(MD_REQUEUE, 6'd42, 1'b1, 32'd7 + k);
        send_event(MD_REMOVE, 6'd0, 1'b0, 32'd12);
        send_event(MD_ADMIT, 6'd7, 1'b0, 32'd13);
        send_event(MD_REQUEUE, 6'd7, 1'b1, 32'd14);       // task 7 on levels 0 and 1
        // Everyone ages: tasks 63 and 7 on level 1 are dropped, others move up.
        send_event(MD_SCHED, 6'd0, 1'b0, 32'hFFFF_FFF0);
        send_event(MD_SCHED, 6'd21, 1'b1, 32'hFFFF_FFF1);
        send_event(MD_ADMIT, 6'd21, 1'b0, 32'hFFFF_FFFF);
        send_event(MD_SCHED, 6'd0, 1'b0, 32'd20);         // wrapped tick difference
        for (int k = 0; k < 6; k++)
            send_event(MD_SCHED, 6'd0, 1'b0, 32'd30 + k);

        write_age_limit(16'd0);
        send_idle_pct = 13;
        recv_idle_pct = 72;
        random_phase(650);

        write_age_limit(16'hFFFF);
        send_idle_pct = 72;
        recv_idle_pct = 13;
        random_phase(650);

        write_age_limit(16'($urandom_range(1, 200)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(650);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_ram.sv
rtl/core/mlfq_cell.sv
rtl/core/mlfq_level.sv
rtl/core/multilevel_feedback_queue_scheduler.sv
rtl/core/mlfq_checker.sv
test/mlfq_checker.sv
test/testbench.sv
